// File: hdl/fiin_pkg.sv
// fiin_pkg: shared types, md5 round tables and helper functions
// used by the round cells, the digest stage and the top level
`default_nettype none

package fiin_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [31:0] PAD_WORD = 32'h00000080;
	localparam logic [31:0] LEN_WORD = 32'd96;
	localparam int unsigned SCAN_OFFSETS = 13;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] t;
		logic [31:0] cell_id;
		logic [31:0] volume_id;
		logic [31:0] vnode_id;
	} md_stage_t;

	typedef struct packed {
		logic [127:0] digest;
		logic [31:0]  fallback;
		logic         vnode_lsb;
	} fin_word_t;

	function automatic logic [31:0] md_k(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md_s(input logic [5:0] r);
		logic [4:0] s;
		unique case ({r[5:4], r[1:0]})
			4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
			4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
			4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
			4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
			4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
			4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
			4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
			4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word index used by round r
	function automatic logic [3:0] md_g(input logic [5:0] r);
		logic [7:0] g;
		unique case (r[5:4])
			2'd0: g = {2'b00, r};
			2'd1: g = {2'b00, r} * 8'd5 + 8'd1;
			2'd2: g = {2'b00, r} * 8'd3 + 8'd5;
			2'd3: g = {2'b00, r} * 8'd7;
		endcase
		return g[3:0];
	endfunction

	// the single padded block: three id words, pad byte, bit length
	function automatic logic [31:0] md_msg(input logic [3:0] g, input md_stage_t st);
		logic [31:0] m;
		unique case (g)
			4'd0:    m = st.cell_id;
			4'd1:    m = st.volume_id;
			4'd2:    m = st.vnode_id;
			4'd3:    m = PAD_WORD;
			4'd14:   m = LEN_WORD;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] w;
		w = {x, x} << s;
		return w[63:32];
	endfunction

endpackage

`default_nettype wire

// File: hdl/fiin_round_cell.sv
// fiin_round_cell: one md5 round with its state register
// depends on fiin_pkg for tables and the stage type
`default_nettype none

module fiin_round_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic [5:0]         round_idx,
	input  wire logic               in_valid,
	input  wire fiin_pkg::md_stage_t in_st,
	output logic                    out_valid,
	output fiin_pkg::md_stage_t     out_st
);
	import fiin_pkg::*;

	logic [31:0] f;
	logic [31:0] rot;
	logic [5:0]  next_idx;
	md_stage_t   nxt;
	logic        valid_q;
	md_stage_t   st_q;

	assign next_idx = round_idx + 6'd1;

	always_comb begin
		unique case (round_idx[5:4])
			2'd0: f = (in_st.b & in_st.c) | (~in_st.b & in_st.d);
			2'd1: f = (in_st.d & in_st.b) | (~in_st.d & in_st.c);
			2'd2: f = in_st.b ^ in_st.c ^ in_st.d;
			2'd3: f = in_st.c ^ (in_st.b | ~in_st.d);
		endcase
		rot = rotl32(f + in_st.t, md_s(round_idx));
		nxt = in_st;
		nxt.a = in_st.d;
		nxt.d = in_st.c;
		nxt.c = in_st.b;
		nxt.b = in_st.b + rot;
		// next round adds its a, which is this round's d
		nxt.t = in_st.d + md_k(next_idx) + md_msg(md_g(next_idx), in_st);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_st    = st_q;

endmodule

`default_nettype wire

// File: hdl/fiin_digest.sv
// fiin_digest: final md5 feed-forward and fallback number
// depends on fiin_pkg for the iv constants and stage types
`default_nettype none

module fiin_digest (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire fiin_pkg::md_stage_t in_st,
	output logic                    out_valid,
	output fiin_pkg::fin_word_t     out_word
);
	import fiin_pkg::*;

	logic      valid_q;
	fin_word_t word_q;
	fin_word_t nxt;

	always_comb begin
		nxt.digest    = {IV_D + in_st.d, IV_C + in_st.c, IV_B + in_st.b, IV_A + in_st.a};
		nxt.fallback  = {in_st.volume_id[15:0], 16'h0000} + in_st.vnode_id;
		nxt.vnode_lsb = in_st.vnode_id[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

`default_nettype wire

// File: hdl/file_id_md5_inode_number.sv
// file_id_md5_inode_number: top level, input stage, chain of 64 round cells,
// digest stage, offset scan and output register with skid
// depends on fiin_pkg, fiin_round_cell and fiin_digest
//
// usage
// s_axis carries one file id word a cycle while s_axis_tready is high: cell, volume and vnode ids.
// m_axis returns one inode number word for every accepted input word.
// cfg_valid/cfg_data write hash_enable; cfg_ready is always high.
// with hash_enable at 1 the number comes from the md5 digest of the id when
// a byte offset qualifies, otherwise from (volume << 16) + vnode, in both cases 31 bits.
// a result word is presented once its input word has passed through the
// 64 round cells, the digest stage and the output register.
// throughput: one word per cycle while m_axis keeps up, with one round cell per md5 round.
// when m_axis stalls the output word holds, the next finished word lands in the
// skid register, then s_axis_tready drops and the whole chain freezes.
// reset clears hash_enable and every valid flag; words in flight are lost.
`default_nettype none

module file_id_md5_inode_number (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_data,       // hash_enable
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,   // cell_id, volume_id, vnode_id
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // inode_number, zero
);
	import fiin_pkg::*;

	localparam int unsigned ROUNDS = 64;

	logic                hash_enable_q;
	logic                adv;
	wire logic [ROUNDS:0] chain_valid;
	wire md_stage_t      chain_st [ROUNDS+1];
	logic                fin_valid;
	fin_word_t           fin_word;
	logic                found;
	logic [30:0]         hash_ino;
	logic [30:0]         cand;
	logic [31:0]         win;
	logic [30:0]         sel_ino;
	logic                out_free;
	logic                out_valid_q;
	logic [30:0]         out_data_q;
	logic                skid_valid_q;
	logic [30:0]         skid_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			hash_enable_q <= cfg_data[0];
		end
	end

	assign adv           = !skid_valid_q;
	assign s_axis_tready = adv;

	assign chain_valid[0] = s_axis_tvalid && s_axis_tready;
	assign chain_st[0]    = '{
		a:         IV_A,
		b:         IV_B,
		c:         IV_C,
		d:         IV_D,
		t:         IV_A + md_k(6'd0) + s_axis_tdata[31:0],
		cell_id:   s_axis_tdata[31:0],
		volume_id: s_axis_tdata[63:32],
		vnode_id:  s_axis_tdata[95:64]
	};

	for (genvar r = 0; r < ROUNDS; r++) begin : g_cell
		fiin_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.round_idx (6'(r)),
			.in_valid  (chain_valid[r]),
			.in_st     (chain_st[r]),
			.out_valid (chain_valid[r+1]),
			.out_st    (chain_st[r+1])
		);
	end

	fiin_digest u_digest (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (chain_valid[ROUNDS]),
		.in_st     (chain_st[ROUNDS]),
		.out_valid (fin_valid),
		.out_word  (fin_word)
	);

	// first byte offset whose word has a nonzero bit in 30:1
	always_comb begin
		found    = 1'b0;
		hash_ino = '0;
		win      = '0;
		cand     = '0;
		for (int unsigned off = 0; off < SCAN_OFFSETS; off++) begin
			win  = fin_word.digest[8*off +: 32];
			cand = {win[30:1], fin_word.vnode_lsb};
			if (!found && (cand[30:1] != '0)) begin
				found    = 1'b1;
				hash_ino = cand;
			end
		end
		sel_ino = (hash_enable_q && found) ? hash_ino : fin_word.fallback[30:0];
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= adv && fin_valid;
				end
			end else if (adv && fin_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= sel_ino;
			end
		end else if (adv && fin_valid) begin
			skid_data_q <= sel_ino;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_data_q};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held while output register empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !m_axis_tready |=> skid_valid_q)
		else $error("skid word dropped without output being taken");

	a_first_cell: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> chain_valid[1])
		else $error("accepted word did not enter the first round cell");

	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(fin_valid) && $stable(chain_valid[ROUNDS:1]))
		else $error("round chain moved while stalled");

endmodule

`default_nettype wire
